// ===== src/chte_pkg.sv =====
// Shared constants, types and the hash table ROM of the chained hash table engine.
// No dependencies; every other file of the block imports it.
`default_nettype none
package chte_pkg;

  localparam int BUCKETS_DEF    = 256;
  localparam int ENTRIES_DEF    = 1024;
  localparam int KEY_BYTES_DEF  = 8;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KEY_W   = 64;
  localparam int KLEN_W  = 4;
  localparam int VAL_W   = 32;
  localparam int BCNT_W  = 9;
  localparam int COUNT_W = 11;
  localparam int CFG_A_W = 2;

  typedef logic [1:0] req_t;
  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_REMOVE = 2'd1;
  localparam req_t REQ_LOOKUP = 2'd2;
  localparam req_t REQ_CLEAR  = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_DUPLICATE = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_POOL_FULL = 2'd3;

  localparam logic [CFG_A_W-1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_KEY_LENGTH   = 2'd1;

  // Control from the request sequencer to the slot allocator
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } free_ctl_t;

  localparam logic [18:0] HASH_ROM [256] = '{
    19'd358213, 19'd149183, 19'd380867, 19'd117727, 19'd205453, 19'd351859, 19'd157247,
    19'd282911, 19'd168481, 19'd97549, 19'd314641, 19'd29401, 19'd93629, 19'd86399,
    19'd196159, 19'd107687, 19'd312343, 19'd339907, 19'd361843, 19'd293269, 19'd16493,
    19'd54673, 19'd21019, 19'd274783, 19'd129629, 19'd289847, 19'd249853, 19'd127321,
    19'd29581, 19'd122719, 19'd27631, 19'd237911, 19'd150991, 19'd75991, 19'd380839,
    19'd186317, 19'd134681, 19'd271043, 19'd104623, 19'd195229, 19'd58061, 19'd31379,
    19'd184511, 19'd209477, 19'd134947, 19'd194723, 19'd160073, 19'd184073, 19'd342659,
    19'd147209, 19'd291101, 19'd278581, 19'd356143, 19'd19841, 19'd380333, 19'd243701,
    19'd99907, 19'd70099, 19'd90263, 19'd1231, 19'd51929, 19'd327571, 19'd285031,
    19'd300331, 19'd10007, 19'd138107, 19'd358753, 19'd2707, 19'd49529, 19'd234529,
    19'd50989, 19'd161303, 19'd68449, 19'd368857, 19'd3779, 19'd107761, 19'd264463,
    19'd318377, 19'd197753, 19'd314137, 19'd320141, 19'd316037, 19'd354643, 19'd225821,
    19'd53281, 19'd176933, 19'd287341, 19'd375757, 19'd368597, 19'd36919, 19'd179383,
    19'd339323, 19'd230203, 19'd340777, 19'd27803, 19'd326113, 19'd358301, 19'd92767,
    19'd211283, 19'd135899, 19'd179909, 19'd71909, 19'd185947, 19'd95483, 19'd92419,
    19'd36529, 19'd3461, 19'd176329, 19'd170767, 19'd376237, 19'd136963, 19'd264031,
    19'd276151, 19'd281923, 19'd2293, 19'd167677, 19'd317419, 19'd125887, 19'd182387,
    19'd357241, 19'd328651, 19'd109819, 19'd322999, 19'd29759, 19'd50123, 19'd160627,
    19'd174337, 19'd323137, 19'd249833, 19'd1787, 19'd51859, 19'd134707, 19'd106109,
    19'd215261, 19'd336593, 19'd308309, 19'd341057, 19'd233417, 19'd307189, 19'd93901,
    19'd364223, 19'd332011, 19'd98627, 19'd152833, 19'd259169, 19'd137873, 19'd311111,
    19'd80783, 19'd53777, 19'd278717, 19'd121883, 19'd362443, 19'd261823, 19'd267481,
    19'd263009, 19'd189697, 19'd89627, 19'd329297, 19'd151153, 19'd203909, 19'd219829,
    19'd138077, 19'd266899, 19'd295567, 19'd233983, 19'd164581, 19'd257069, 19'd62627,
    19'd51721, 19'd201953, 19'd265271, 19'd12697, 19'd72907, 19'd373553, 19'd359663,
    19'd228539, 19'd50993, 19'd346589, 19'd6977, 19'd331307, 19'd32467, 19'd92233,
    19'd378997, 19'd40213, 19'd22247, 19'd178513, 19'd314453, 19'd196051, 19'd88471,
    19'd243479, 19'd251707, 19'd7559, 19'd174599, 19'd42281, 19'd3529, 19'd134923,
    19'd105397, 19'd123593, 19'd224771, 19'd289469, 19'd17123, 19'd115057, 19'd17881,
    19'd272059, 19'd284737, 19'd78781, 19'd321077, 19'd223211, 19'd171559, 19'd252409,
    19'd59359, 19'd342343, 19'd109133, 19'd368789, 19'd222977, 19'd153337, 19'd184271,
    19'd376633, 19'd189887, 19'd361451, 19'd300163, 19'd8819, 19'd248021, 19'd349133,
    19'd235447, 19'd79601, 19'd277657, 19'd73757, 19'd139883, 19'd280811, 19'd36161,
    19'd191861, 19'd6361, 19'd198469, 19'd363611, 19'd332309, 19'd141223, 19'd378733,
    19'd176651, 19'd167801, 19'd336263, 19'd305839, 19'd11173, 19'd44909, 19'd61543,
    19'd340979, 19'd95881, 19'd143947, 19'd60217, 19'd133351, 19'd141761, 19'd225221,
    19'd250993, 19'd167593, 19'd317431, 19'd52697
  };

endpackage
`default_nettype wire

// ===== src/chained_hash_table_engine.sv =====
// Top level of the chained hash table engine: request sequencer, bucket head
// and entry memories. Depends on chte_pkg, chte_hash and chte_free.
//
// One request is worked at a time. A request hashes the key bytes and takes the
// remainder, fetches the bucket head, walks the chain with one entry-memory read
// per entry visited, then updates and reports. A clear, and the start after
// reset, sweeps the bucket head memory one bucket per cycle while no request
// is taken. A new request is taken while a result still waits on the output.
`default_nettype none
module chained_hash_table_engine
  import chte_pkg::*;
#(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [103:0]        s_axis_tdata,  // key[63:0], key_length[67:64], value[99:68]
  input  wire logic [1:0]          s_axis_tuser,  // req_type[1:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [47:0]              m_axis_tdata,  // status[1:0], found_value[33:2], item_count[44:34]
  input  wire logic                cfg_we,
  input  wire logic [CFG_A_W-1:0]  cfg_addr,
  input  wire logic [BCNT_W-1:0]   cfg_wdata
);

  localparam int EB = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int HB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [KLEN_W-1:0]     len;
    logic [VALUE_BITS-1:0] value;
    logic [LW-1:0]         link;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HREAD, S_HEAD, S_CHECK, S_CMP, S_ACT, S_LINK, S_DONE
  } state_t;

  // configuration
  logic [BCNT_W-1:0] bucket_count;
  logic [KLEN_W-1:0] key_length_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count    <= BCNT_W'(256);
      key_length_mode <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_BUCKET_COUNT) begin
        bucket_count <= cfg_wdata;
      end else if (cfg_addr == CFG_KEY_LENGTH) begin
        key_length_mode <= cfg_wdata[KLEN_W-1:0];
      end
    end
  end

  // request decode
  req_t              in_req;
  logic [KEY_W-1:0]  in_key;
  logic [KLEN_W-1:0] in_len_raw;
  logic [KLEN_W-1:0] in_len;
  logic [KEY_W-1:0]  in_key_m;
  logic              accept;

  assign in_req     = s_axis_tuser;
  assign in_key     = s_axis_tdata[63:0];
  assign in_len_raw = (key_length_mode != '0) ? key_length_mode : s_axis_tdata[67:64];

  always_comb begin
    in_len = in_len_raw;
    if (32'(in_len_raw) > KEY_BYTES) begin
      in_len = KLEN_W'(KEY_BYTES);
    end
    for (int i = 0; i < 8; i++) begin
      in_key_m[8*i +: 8] = (i < 32'(in_len)) ? in_key[8*i +: 8] : 8'h00;
    end
  end

  state_t state;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // hash unit
  logic              hash_done;
  logic [BCNT_W-1:0] hash_bucket;

  chte_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && (in_req != REQ_CLEAR)),
    .key          (in_key_m),
    .key_len      (in_len),
    .bucket_count (bucket_count),
    .done         (hash_done),
    .bucket       (hash_bucket)
  );

  // request registers
  req_t                  req;
  logic [KEY_W-1:0]      key_r;
  logic [KLEN_W-1:0]     len_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [HB-1:0]         bucket_r;
  logic [LW-1:0]         cur;
  logic [LW-1:0]         prev;
  entry_t                prev_word;
  logic [LW-1:0]         steps;
  logic                  hit;
  logic [HB-1:0]         clr_idx;
  logic                  clr_report;
  logic [EB-1:0]         slot_r;
  logic [LW-1:0]         held;
  status_t               status_r;
  logic [VAL_W-1:0]      found_r;

  // memories
  logic [LW-1:0] heads_mem [BUCKETS];
  entry_t        ent_mem [ENTRIES];
  logic [LW-1:0] heads_rd;
  entry_t        ent_rd;
  logic          heads_we;
  logic [HB-1:0] heads_wa;
  logic [LW-1:0] heads_wd;
  logic          ent_we;
  logic [EB-1:0] ent_wa;
  entry_t        ent_wd;
  logic          ent_re;

  free_ctl_t     free_ctl;
  logic          free_empty;
  logic [EB-1:0] free_slot;

  chte_free #(.ENTRIES(ENTRIES)) u_free (
    .clk       (clk),
    .rst       (rst),
    .ctl       (free_ctl),
    .push_slot (cur[EB-1:0]),
    .empty     (free_empty),
    .slot      (free_slot)
  );

  logic add_ok;
  logic chain_end;
  assign add_ok    = (req == REQ_ADD) && !hit && !free_empty;
  assign chain_end = (cur >= NIL) || (32'(steps) >= ENTRIES);

  always_comb begin
    heads_we = 1'b0;
    heads_wa = bucket_r;
    heads_wd = NIL;
    ent_we   = 1'b0;
    ent_wa   = prev[EB-1:0];
    ent_wd   = prev_word;
    ent_re   = (state == S_CHECK) && !chain_end;
    free_ctl = '0;
    case (state)
      S_CLEAR: begin
        heads_we       = 1'b1;
        heads_wa       = clr_idx;
        free_ctl.clear = 1'b1;
      end
      S_ACT: begin
        if (add_ok) begin
          ent_we       = 1'b1;
          ent_wa       = free_slot;
          ent_wd.key   = key_r;
          ent_wd.len   = len_r;
          ent_wd.value = val_r;
          ent_wd.link  = NIL;
          free_ctl.pop = 1'b1;
        end else if ((req == REQ_REMOVE) && hit) begin
          // unlink the hit entry and return its slot
          free_ctl.push = 1'b1;
          if (prev >= NIL) begin
            heads_we = 1'b1;
            heads_wd = ent_rd.link;
          end else begin
            ent_we      = 1'b1;
            ent_wd.link = ent_rd.link;
          end
        end
      end
      S_LINK: begin
        if (prev >= NIL) begin
          heads_we = 1'b1;
          heads_wd = LW'(slot_r);
        end else begin
          ent_we      = 1'b1;
          ent_wd.link = LW'(slot_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    heads_rd <= heads_mem[bucket_r];
    if (heads_we) begin
      heads_mem[heads_wa] <= heads_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_re) begin
      ent_rd <= ent_mem[cur[EB-1:0]];
    end
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      clr_report    <= 1'b0;
      held          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + HB'(1);
          held    <= '0;
          if (clr_idx == HB'(BUCKETS - 1)) begin
            clr_idx  <= '0;
            status_r <= ST_OK;
            found_r  <= '0;
            state    <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req   <= in_req;
            key_r <= in_key_m;
            len_r <= in_len;
            val_r <= VALUE_BITS'(s_axis_tdata[99:68]);
            if (in_req == REQ_CLEAR) begin
              clr_report <= 1'b1;
              state      <= S_CLEAR;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bucket_r <= HB'(hash_bucket);
            state    <= S_HREAD;
          end
        end
        S_HREAD: state <= S_HEAD;
        S_HEAD: begin
          cur   <= heads_rd;
          prev  <= NIL;
          steps <= '0;
          hit   <= 1'b0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= chain_end ? S_ACT : S_CMP;
        end
        S_CMP: begin
          if ((ent_rd.len == len_r) && (ent_rd.key == key_r)) begin
            hit   <= 1'b1;
            state <= S_ACT;
          end else begin
            prev      <= cur;
            prev_word <= ent_rd;
            cur       <= ent_rd.link;
            steps     <= steps + LW'(1);
            state     <= S_CHECK;
          end
        end
        S_ACT: begin
          found_r  <= '0;
          status_r <= ST_OK;
          state    <= S_DONE;
          case (req)
            REQ_ADD: begin
              if (hit) begin
                status_r <= ST_DUPLICATE;
              end else if (free_empty) begin
                status_r <= ST_POOL_FULL;
              end else begin
                slot_r <= free_slot;
                held   <= held + LW'(1);
                state  <= S_LINK;
              end
            end
            REQ_REMOVE: begin
              if (!hit) begin
                status_r <= ST_NOT_FOUND;
              end else if (held != '0) begin
                held <= held - LW'(1);
              end
            end
            REQ_LOOKUP: begin
              if (!hit) begin
                status_r <= ST_NOT_FOUND;
              end else begin
                found_r <= VAL_W'(ent_rd.value);
              end
            end
            default: ;
          endcase
        end
        S_LINK: state <= S_DONE;
        S_DONE: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {3'b000, COUNT_W'(held), found_r, status_r};
            m_axis_tvalid <= 1'b1;
            clr_report    <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/chte_hash.sv =====
// Bucket hash unit: one key byte per cycle through the ROM, then a bit-serial
// remainder by the bucket count. Depends on chte_pkg.
`default_nettype none
module chte_hash
  import chte_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [KLEN_W-1:0] key_len,
  input  wire logic [BCNT_W-1:0] bucket_count,
  output logic                   done,
  output logic [BCNT_W-1:0]      bucket
);

  typedef enum logic [1:0] {H_IDLE, H_BYTE, H_DIV} hstate_t;

  hstate_t            state;
  logic [KEY_W-1:0]   key_sh;
  logic [KLEN_W-1:0]  left;
  logic [31:0]        acc;
  logic [30:0]        quo;
  logic [4:0]         bit_cnt;
  logic [BCNT_W:0]    rem;
  logic [BCNT_W-1:0]  divisor;
  logic [BCNT_W-1:0]  div_next;
  logic [7:0]         rom_idx;
  logic [31:0]        acc_next;
  logic [BCNT_W:0]    rem_sh;

  always_comb begin
    div_next = bucket_count;
    if (bucket_count == '0) begin
      div_next = BCNT_W'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      div_next = BCNT_W'(BUCKETS);
    end
    rom_idx  = key_sh[7:0] + acc[7:0];
    acc_next = acc + 32'(HASH_ROM[rom_idx]);
    rem_sh   = {rem[BCNT_W-1:0], quo[30]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      state <= H_IDLE;
    end else begin
      done <= (state == H_DIV) && (bit_cnt == 5'd30);
      case (state)
        H_IDLE: begin
          if (start) begin
            key_sh  <= key;
            left    <= key_len;
            acc     <= 32'd1;
            divisor <= div_next;
            state   <= H_BYTE;
          end
        end
        H_BYTE: begin
          if (left == '0) begin
            quo     <= acc[31:1];
            rem     <= '0;
            bit_cnt <= '0;
            state   <= H_DIV;
          end else begin
            acc    <= acc_next;
            key_sh <= key_sh >> 8;
            left   <= left - KLEN_W'(1);
          end
        end
        H_DIV: begin
          // restoring remainder, one dividend bit per cycle
          if (rem_sh >= {1'b0, divisor}) begin
            rem <= rem_sh - {1'b0, divisor};
          end else begin
            rem <= rem_sh;
          end
          quo     <= {quo[29:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'd30) begin
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  assign bucket = rem[BCNT_W-1:0];

endmodule
`default_nettype wire

// ===== src/chte_free.sv =====
// Slot allocator: never-used slots are handed out in order, returned slots are
// kept on a stack memory and reused first. Depends on chte_pkg.
`default_nettype none
module chte_free
  import chte_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire free_ctl_t                    ctl,
  input  wire logic [$clog2(ENTRIES)-1:0]   push_slot,
  output logic                              empty,
  output logic [$clog2(ENTRIES)-1:0]        slot
);

  localparam int EB = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  logic [EB-1:0] stack_mem [ENTRIES];
  logic [EB-1:0] top_rd;
  logic [LW-1:0] ret_cnt;
  logic [LW-1:0] fresh;
  logic [LW-1:0] top_addr;

  assign top_addr = ret_cnt - LW'(1);
  assign empty    = (ret_cnt == '0) && (fresh == LW'(ENTRIES));
  assign slot     = (ret_cnt != '0) ? top_rd : fresh[EB-1:0];

  // top entry is read every cycle; the count is stable long before a pop
  always_ff @(posedge clk) begin
    top_rd <= stack_mem[top_addr[EB-1:0]];
    if (ctl.push) begin
      stack_mem[ret_cnt[EB-1:0]] <= push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      ret_cnt <= '0;
      fresh   <= '0;
    end else if (ctl.push) begin
      ret_cnt <= ret_cnt + LW'(1);
    end else if (ctl.pop) begin
      if (ret_cnt != '0) begin
        ret_cnt <= ret_cnt - LW'(1);
      end else begin
        fresh <= fresh + LW'(1);
      end
    end
  end

endmodule
`default_nettype wire
